>>> sv/lacb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lacb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int THRESH_WIDTH    = 32;

  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 32'd1;
  localparam logic [30:0]             ONE_Q30      = 31'h4000_0000;

  localparam int SQ_STEPS        = 32;
  localparam int DV_STEPS        = 31;
  localparam int STEPS_PER_STAGE = 2;
  localparam int SQ_STAGES       = (SQ_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DV_STAGES       = (DV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam int CROSS_LAT = 6;
  localparam int NORM_LAT  = 4 + SQ_STAGES + DV_STAGES + 2;
  localparam int ORTHO_LAT = 2;
  localparam int TOTAL_LAT = CROSS_LAT + NORM_LAT + ORTHO_LAT;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_SAME_POINT = 2'd1,
    ERR_ZERO_UP    = 2'd2,
    ERR_DEGENERATE = 2'd3
  } err_e;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] low;
    logic [30:0] quo;
  } div_t;

  function automatic sqrt_t sqrt_step(sqrt_t s, int k);
    logic [63:0] bitv;
    logic [64:0] trial;
    sqrt_t       r;
    bitv  = 64'd1 << (62 - 2 * k);
    trial = {1'b0, s.res} + {1'b0, bitv};
    if ({1'b0, s.x} >= trial) begin
      r.x   = s.x - trial[63:0];
      r.res = (s.res >> 1) + bitv;
    end else begin
      r.x   = s.x;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  function automatic div_t div_step(div_t d, logic [31:0] len);
    logic [32:0] r2;
    div_t        o;
    r2    = {d.rem, d.low[30]};
    o.low = {d.low[29:0], 1'b0};
    if (r2 >= {1'b0, len}) begin
      o.rem = 32'(r2 - {1'b0, len});
      o.quo = {d.quo[29:0], 1'b1};
    end else begin
      o.rem = r2[31:0];
      o.quo = {d.quo[29:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> sv/look_at_camera_basis.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes in order through view and cross, then normalization with
// 16 square-root stages of two bits each and 16 division stages of two bits each but
// the last, which does one, then the orthogonal up vector. Throughput is one item
// per cycle, but the whole pipeline holds while a finished result waits at the output.
// Reset clears the valid bits of every stage and sets the threshold to 1.
module look_at_camera_basis #(
  parameter int COORD_WIDTH = lacb_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] eye_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] eye_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] eye_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] target_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] target_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] target_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] upward_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] upward_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] upward_z_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [lacb_pkg::THRESH_WIDTH-1:0] cfg_wdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0] right_x_o,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0] right_y_o,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0] right_z_o,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0] ortho_up_x_o,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0] ortho_up_y_o,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0] ortho_up_z_o,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0] back_x_o,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0] back_y_o,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0] back_z_o,
  output logic [1:0]                         error_code_o
);
  import lacb_pkg::*;

  localparam int MW = 2 * COORD_WIDTH + 1;

  logic                           en;
  logic [TOTAL_LAT-1:0]           vld_q;
  logic [THRESH_WIDTH-1:0]        thresh_q;
  logic signed [COORD_WIDTH-1:0]  eye [3], target [3], upward [3];
  err_e                           cerr, oerr;
  err_e                           err_dly_q [NORM_LAT];
  logic [MW-1:0]                  cmag [3], vmag [3];
  logic                           cneg [3], vneg [3];
  logic signed [OUT_WIDTH-1:0]    rn [3], vn [3], right [3], up [3], back [3];

  assign en         = !vld_q[TOTAL_LAT-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[TOTAL_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      thresh_q <= THRESH_RESET;
    end else begin
      if (en) begin
        vld_q <= {vld_q[TOTAL_LAT-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    eye[0]    = eye_x_i;
    eye[1]    = eye_y_i;
    eye[2]    = eye_z_i;
    target[0] = target_x_i;
    target[1] = target_y_i;
    target[2] = target_z_i;
    upward[0] = upward_x_i;
    upward[1] = upward_y_i;
    upward[2] = upward_z_i;
  end

  lacb_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk_i    (clk_i),
    .en_i     (en),
    .thresh_i (thresh_q),
    .eye_i    (eye),
    .target_i (target),
    .upward_i (upward),
    .err_o    (cerr),
    .cmag_o   (cmag),
    .cneg_o   (cneg),
    .vmag_o   (vmag),
    .vneg_o   (vneg)
  );

  lacb_norm #(.MAG_WIDTH(MW)) u_norm_right (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (cmag),
    .neg_i  (cneg),
    .unit_o (rn)
  );

  lacb_norm #(.MAG_WIDTH(MW)) u_norm_view (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (vmag),
    .neg_i  (vneg),
    .unit_o (vn)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_dly_q[0] <= cerr;
      for (int s = 1; s < NORM_LAT; s++) begin
        err_dly_q[s] <= err_dly_q[s-1];
      end
    end
  end

  lacb_ortho u_ortho (
    .clk_i   (clk_i),
    .en_i    (en),
    .err_i   (err_dly_q[NORM_LAT-1]),
    .rn_i    (rn),
    .vn_i    (vn),
    .err_o   (oerr),
    .right_o (right),
    .up_o    (up),
    .back_o  (back)
  );

  assign right_x_o    = right[0];
  assign right_y_o    = right[1];
  assign right_z_o    = right[2];
  assign ortho_up_x_o = up[0];
  assign ortho_up_y_o = up[1];
  assign ortho_up_z_o = up[2];
  assign back_x_o     = back[0];
  assign back_y_o     = back[1];
  assign back_z_o     = back[2];
  assign error_code_o = oerr;

endmodule
`default_nettype wire

>>> sv/lacb_cross.sv
`timescale 1ns / 1ps
`default_nettype none
module lacb_cross #(
  parameter int CW = lacb_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic [lacb_pkg::THRESH_WIDTH-1:0]      thresh_i,
  input  wire logic signed [CW-1:0]                   eye_i    [3],
  input  wire logic signed [CW-1:0]                   target_i [3],
  input  wire logic signed [CW-1:0]                   upward_i [3],
  output lacb_pkg::err_e                              err_o,
  output logic [2*CW:0]                               cmag_o   [3],
  output logic                                        cneg_o   [3],
  output logic [2*CW:0]                               vmag_o   [3],
  output logic                                        vneg_o   [3]
);
  import lacb_pkg::*;

  localparam int VW  = CW + 1;
  localparam int PW  = 2 * CW + 1;
  localparam int CRW = 2 * CW + 2;
  localparam int MW  = 2 * CW + 1;

  logic signed [VW-1:0]  view_d [3];
  logic signed [VW-1:0]  view1_q [3], view2_q [3], view3_q [3];
  logic signed [CW-1:0]  up1_q [3];
  logic                  same1_q, same2_q, same3_q, same4_q, same5_q;
  logic                  zup1_q, zup2_q, zup3_q, zup4_q, zup5_q;
  logic signed [PW-1:0]  va [3], ua [3];
  logic signed [PW-1:0]  prod_d [6], prod_q [6];
  logic signed [CRW-1:0] c_d [3], c_q [3];
  logic [CRW-1:0]        cabs [3];
  logic [MW-1:0]         cmag4_q [3], cmag5_q [3], cmag6_q [3];
  logic                  cneg4_q [3], cneg5_q [3], cneg6_q [3];
  logic [MW-1:0]         vmag4_q [3], vmag5_q [3], vmag6_q [3];
  logic                  vneg4_q [3], vneg5_q [3], vneg6_q [3];
  logic [VW-1:0]         vabs [3];
  logic                  big4_q, zero4_q, big5_q, zero5_q;
  logic [63:0]           sq5_q [3];
  logic [65:0]           sum;
  logic                  degen;
  err_e                  err_d, err6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      view_d[i] = VW'(target_i[i]) - VW'(eye_i[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = PW'(view1_q[i]);
      ua[i] = PW'(up1_q[i]);
    end
    prod_d[0] = va[1] * ua[2];
    prod_d[1] = va[2] * ua[1];
    prod_d[2] = va[2] * ua[0];
    prod_d[3] = va[0] * ua[2];
    prod_d[4] = va[0] * ua[1];
    prod_d[5] = va[1] * ua[0];
    for (int i = 0; i < 3; i++) begin
      c_d[i] = CRW'(prod_q[2*i]) - CRW'(prod_q[2*i+1]);
      cabs[i] = c_q[i][CRW-1] ? CRW'(-c_q[i]) : CRW'(c_q[i]);
      vabs[i] = view3_q[i][VW-1] ? VW'(-view3_q[i]) : VW'(view3_q[i]);
    end
  end

  always_comb begin
    sum   = 66'(sq5_q[0]) + 66'(sq5_q[1]) + 66'(sq5_q[2]);
    degen = zero5_q || (!big5_q && (sum[65:32] < {2'b00, thresh_i}));
    if (same5_q) begin
      err_d = ERR_SAME_POINT;
    end else if (zup5_q) begin
      err_d = ERR_ZERO_UP;
    end else if (degen) begin
      err_d = ERR_DEGENERATE;
    end else begin
      err_d = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        view1_q[i] <= view_d[i];
        up1_q[i]   <= upward_i[i];
        view2_q[i] <= view1_q[i];
        view3_q[i] <= view2_q[i];
        c_q[i]     <= c_d[i];
        cmag4_q[i] <= cabs[i][MW-1:0];
        cneg4_q[i] <= c_q[i][CRW-1];
        vmag4_q[i] <= MW'(vabs[i]);
        vneg4_q[i] <= view3_q[i][VW-1];
        sq5_q[i]   <= cmag4_q[i][31:0] * cmag4_q[i][31:0];
        cmag5_q[i] <= cmag4_q[i];
        cneg5_q[i] <= cneg4_q[i];
        vmag5_q[i] <= vmag4_q[i];
        vneg5_q[i] <= vneg4_q[i];
        cmag6_q[i] <= cmag5_q[i];
        cneg6_q[i] <= cneg5_q[i];
        vmag6_q[i] <= vmag5_q[i];
        vneg6_q[i] <= vneg5_q[i];
      end
      for (int j = 0; j < 6; j++) begin
        prod_q[j] <= prod_d[j];
      end
      same1_q <= (view_d[0] == '0) && (view_d[1] == '0) && (view_d[2] == '0);
      zup1_q  <= (upward_i[0] == '0) && (upward_i[1] == '0) && (upward_i[2] == '0);
      same2_q <= same1_q;
      zup2_q  <= zup1_q;
      same3_q <= same2_q;
      zup3_q  <= zup2_q;
      same4_q <= same3_q;
      zup4_q  <= zup3_q;
      big4_q  <= (|cabs[0][MW-1:32]) || (|cabs[1][MW-1:32]) || (|cabs[2][MW-1:32]);
      zero4_q <= (cabs[0] == '0) && (cabs[1] == '0) && (cabs[2] == '0);
      same5_q <= same4_q;
      zup5_q  <= zup4_q;
      big5_q  <= big4_q;
      zero5_q <= zero4_q;
      err6_q  <= err_d;
    end
  end

  assign err_o  = err6_q;
  assign cmag_o = cmag6_q;
  assign cneg_o = cneg6_q;
  assign vmag_o = vmag6_q;
  assign vneg_o = vneg6_q;

endmodule
`default_nettype wire

>>> sv/lacb_norm.sv
`timescale 1ns / 1ps
`default_nettype none
module lacb_norm #(
  parameter int MAG_WIDTH = 2 * lacb_pkg::COORD_WIDTH_DEF + 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic [MAG_WIDTH-1:0]                mag_i [3],
  input  wire logic                                neg_i [3],
  output logic signed [lacb_pkg::OUT_WIDTH-1:0]    unit_o [3]
);
  import lacb_pkg::*;

  localparam int BLW = $clog2(MAG_WIDTH + 1);

  logic [MAG_WIDTH-1:0] orv;
  logic [BLW-1:0]       bl_d, bl1_q;
  logic [MAG_WIDTH-1:0] mag1_q [3];
  logic                 neg1_q [3], neg2_q [3], neg3_q [3];
  logic [30:0]          m_d [3], m2_q [3], m3_q [3];
  logic [61:0]          sq3_q [3];

  sqrt_t                sqs_d [SQ_STAGES+1];
  sqrt_t                sqs_q [SQ_STAGES+1];
  logic [30:0]          msq_q [SQ_STAGES+1][3];
  logic                 nsq_q [SQ_STAGES+1][3];

  logic [31:0]          len_d;
  logic [61:0]          dvd [3];
  div_t                 dv_d [DV_STAGES+1][3];
  div_t                 dv_q [DV_STAGES+1][3];
  logic [31:0]          len_q [DV_STAGES+1];
  logic                 ndv_q [DV_STAGES+1][3];
  logic [30:0]          quo [3];
  logic [31:0]          umag [3];
  logic signed [OUT_WIDTH-1:0] unit_q [3];

  always_comb begin
    orv  = mag_i[0] | mag_i[1] | mag_i[2];
    bl_d = '0;
    for (int b = 0; b < MAG_WIDTH; b++) begin
      if (orv[b]) begin
        bl_d = BLW'(b + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (bl1_q > BLW'(31)) begin
        m_d[i] = 31'(mag1_q[i] >> (bl1_q - BLW'(31)));
      end else begin
        m_d[i] = mag1_q[i][30:0] << (BLW'(31) - bl1_q);
      end
    end
  end

  always_comb begin
    sqs_d[0].x   = 64'(sq3_q[0]) + 64'(sq3_q[1]) + 64'(sq3_q[2]);
    sqs_d[0].res = '0;
    for (int s = 0; s < SQ_STAGES; s++) begin
      sqs_d[s+1] = sqs_q[s];
      for (int t = 0; t < STEPS_PER_STAGE; t++) begin
        if (s * STEPS_PER_STAGE + t < SQ_STEPS) begin
          sqs_d[s+1] = sqrt_step(sqs_d[s+1], s * STEPS_PER_STAGE + t);
        end
      end
    end
  end

  always_comb begin
    len_d = (sqs_q[SQ_STAGES].res == '0) ? 32'd1 : sqs_q[SQ_STAGES].res[31:0];
    for (int i = 0; i < 3; i++) begin
      dvd[i]          = {1'b0, msq_q[SQ_STAGES][i], 30'd0} + {31'd0, len_d[31:1]};
      dv_d[0][i].rem  = {1'b0, dvd[i][61:31]};
      dv_d[0][i].low  = dvd[i][30:0];
      dv_d[0][i].quo  = '0;
    end
    for (int s = 0; s < DV_STAGES; s++) begin
      for (int i = 0; i < 3; i++) begin
        dv_d[s+1][i] = dv_q[s][i];
        for (int t = 0; t < STEPS_PER_STAGE; t++) begin
          if (s * STEPS_PER_STAGE + t < DV_STEPS) begin
            dv_d[s+1][i] = div_step(dv_d[s+1][i], len_q[s]);
          end
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      quo[i]  = dv_q[DV_STAGES][i].quo;
      umag[i] = {1'b0, (quo[i] > ONE_Q30) ? ONE_Q30 : quo[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bl1_q <= bl_d;
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= mag_i[i];
        neg1_q[i] <= neg_i[i];
        m2_q[i]   <= m_d[i];
        neg2_q[i] <= neg1_q[i];
        sq3_q[i]  <= m2_q[i] * m2_q[i];
        m3_q[i]   <= m2_q[i];
        neg3_q[i] <= neg2_q[i];
        msq_q[0][i] <= m3_q[i];
        nsq_q[0][i] <= neg3_q[i];
        ndv_q[0][i] <= nsq_q[SQ_STAGES][i];
        unit_q[i] <= ndv_q[DV_STAGES][i] ? OUT_WIDTH'(-umag[i]) : OUT_WIDTH'(umag[i]);
      end
      sqs_q[0] <= sqs_d[0];
      for (int s = 0; s < SQ_STAGES; s++) begin
        sqs_q[s+1] <= sqs_d[s+1];
        for (int i = 0; i < 3; i++) begin
          msq_q[s+1][i] <= msq_q[s][i];
          nsq_q[s+1][i] <= nsq_q[s][i];
        end
      end
      len_q[0] <= len_d;
      for (int i = 0; i < 3; i++) begin
        dv_q[0][i] <= dv_d[0][i];
      end
      for (int s = 0; s < DV_STAGES; s++) begin
        len_q[s+1] <= len_q[s];
        for (int i = 0; i < 3; i++) begin
          dv_q[s+1][i]  <= dv_d[s+1][i];
          ndv_q[s+1][i] <= ndv_q[s][i];
        end
      end
    end
  end

  assign unit_o = unit_q;

endmodule
`default_nettype wire

>>> sv/lacb_ortho.sv
`timescale 1ns / 1ps
`default_nettype none
module lacb_ortho (
  input  wire logic                                  clk_i,
  input  wire logic                                  en_i,
  input  wire lacb_pkg::err_e                        err_i,
  input  wire logic signed [lacb_pkg::OUT_WIDTH-1:0] rn_i [3],
  input  wire logic signed [lacb_pkg::OUT_WIDTH-1:0] vn_i [3],
  output lacb_pkg::err_e                             err_o,
  output logic signed [lacb_pkg::OUT_WIDTH-1:0]      right_o [3],
  output logic signed [lacb_pkg::OUT_WIDTH-1:0]      up_o    [3],
  output logic signed [lacb_pkg::OUT_WIDTH-1:0]      back_o  [3]
);
  import lacb_pkg::*;

  logic signed [63:0]          ra [3], vb [3];
  logic signed [63:0]          prod_d [6], prod_q [6];
  logic signed [OUT_WIDTH-1:0] rn1_q [3], vn1_q [3];
  err_e                        err1_q, err2_q;
  logic signed [64:0]          diff [3];
  logic [64:0]                 dmag [3];
  logic [34:0]                 rnd [3];
  logic [31:0]                 umag [3];
  logic                        ok;
  logic signed [OUT_WIDTH-1:0] right_q [3], up_q [3], back_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ra[i] = 64'(rn_i[i]);
      vb[i] = 64'(vn_i[i]);
    end
    prod_d[0] = ra[1] * vb[2];
    prod_d[1] = ra[2] * vb[1];
    prod_d[2] = ra[2] * vb[0];
    prod_d[3] = ra[0] * vb[2];
    prod_d[4] = ra[0] * vb[1];
    prod_d[5] = ra[1] * vb[0];
    ok = (err1_q == ERR_NONE);
    for (int i = 0; i < 3; i++) begin
      diff[i] = 65'(prod_q[2*i]) - 65'(prod_q[2*i+1]);
      dmag[i] = diff[i][64] ? 65'(-diff[i]) : 65'(diff[i]);
      rnd[i]  = 35'((dmag[i] + 65'(64'd1 << 29)) >> 30);
      umag[i] = (rnd[i] > 35'({1'b0, ONE_Q30})) ? {1'b0, ONE_Q30} : rnd[i][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err1_q <= err_i;
      err2_q <= err1_q;
      for (int j = 0; j < 6; j++) begin
        prod_q[j] <= prod_d[j];
      end
      for (int i = 0; i < 3; i++) begin
        rn1_q[i]   <= rn_i[i];
        vn1_q[i]   <= vn_i[i];
        right_q[i] <= ok ? rn1_q[i] : '0;
        back_q[i]  <= ok ? OUT_WIDTH'(-vn1_q[i]) : '0;
        up_q[i]    <= !ok ? '0 :
                      (diff[i][64] ? OUT_WIDTH'(-umag[i]) : OUT_WIDTH'(umag[i]));
      end
    end
  end

  assign err_o   = err2_q;
  assign right_o = right_q;
  assign up_o    = up_q;
  assign back_o  = back_q;

endmodule
`default_nettype wire
